// ===== src/pinv_pkg.sv =====
// Package for the pixel inversion unit.
// Holds the transaction structs, configuration bundle, register indexes and mode codes.
// Depends on nothing.
`default_nettype none

package pinv_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DAT_W = 8;
    localparam int unsigned LUMA_W   = 18;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef enum logic [1:0] {
        MODE_SIMPLE  = 2'd0,
        MODE_CHANNEL = 2'd1,
        MODE_LUMA    = 2'd2,
        MODE_INVALID = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MASK = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_ALPHA  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_THRESH  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR       = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RED   = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_GREEN = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_BLUE  = 8'd7;

    typedef struct packed {
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_alpha;
    } t_pixel_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_alpha;
        logic              bad_mode;
    } t_pixel_out;

    typedef struct packed {
        t_mode             mode;
        logic [3:0]        channel_mask;
        logic              allow_alpha;
        logic [CHAN_W-1:0] luma_threshold;
        logic              mirror_threshold;
        logic [CHAN_W-1:0] weight_red;
        logic [CHAN_W-1:0] weight_green;
        logic [CHAN_W-1:0] weight_blue;
    } t_cfg;

    function automatic logic [CHAN_W-1:0] flip(input logic [CHAN_W-1:0] v);
        return CHAN_MAX - v;
    endfunction

endpackage

`default_nettype wire

// ===== src/pixel_inversion_unit.sv =====
// Top level of the pixel inversion unit.
// Depends on pinv_pkg, pinv_cfg_regs and pinv_core.
`default_nettype none

// Usage:
//   Input: drive i_pixel and raise start; the transaction is taken at the
//   rising edge where start is high and busy is low. busy never rises, so a
//   pixel may be offered in every cycle.
//   Output: o_done is high for exactly one cycle with the result on o_result.
//   The receiver cannot stall; each result is valid for that single cycle.
//   Pipeline: the accepted pixel passes the input register, then the result
//   register, with the luminance products, sum, compare and inversion
//   between them; o_done rises as the result register is loaded.
//   Throughput: one pixel per cycle.
//   Configuration: i_cfg_we writes i_cfg_wdata to the register at
//   i_cfg_index (0 mode, 1 channel_mask, 2 allow_alpha, 3 luma_threshold,
//   4 mirror_threshold, 5..7 red, green, blue weights); other indexes are
//   ignored. Write only while no transaction is in flight.
//   Reset (synchronous, active low) restores register defaults and drops
//   any transaction in flight; o_done is low during and after reset.

module pixel_inversion_unit
    import pinv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_pixel_in            i_pixel,
    output logic                      o_done,
    output t_pixel_out                o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata
);

    t_cfg       cfg;
    t_pixel_out core_out;

    logic       r_in_valid;
    t_pixel_in  r_in_pixel;
    logic       r_out_valid;
    t_pixel_out r_out_pixel;

    pinv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pinv_core u_core (
        .i_cfg   (cfg),
        .i_pixel (r_in_pixel),
        .o_pixel (core_out)
    );

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= start & ~busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_pixel  <= i_pixel;
        r_out_pixel <= core_out;
    end

    assign o_done   = r_out_valid;
    assign o_result = r_out_pixel;

endmodule

`default_nettype wire

// ===== src/pinv_cfg_regs.sv =====
// Configuration register file for the pixel inversion unit.
// Depends on pinv_pkg.
`default_nettype none

module pinv_cfg_regs
    import pinv_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_wdata,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:         n_cfg.mode             = t_mode'(i_cfg_wdata[1:0]);
                CFG_CHANNEL_MASK: n_cfg.channel_mask     = i_cfg_wdata[3:0];
                CFG_ALLOW_ALPHA:  n_cfg.allow_alpha      = i_cfg_wdata[0];
                CFG_LUMA_THRESH:  n_cfg.luma_threshold   = i_cfg_wdata[CHAN_W-1:0];
                CFG_MIRROR:       n_cfg.mirror_threshold = i_cfg_wdata[0];
                CFG_WEIGHT_RED:   n_cfg.weight_red       = i_cfg_wdata[CHAN_W-1:0];
                CFG_WEIGHT_GREEN: n_cfg.weight_green     = i_cfg_wdata[CHAN_W-1:0];
                CFG_WEIGHT_BLUE:  n_cfg.weight_blue      = i_cfg_wdata[CHAN_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode             <= MODE_SIMPLE;
            r_cfg.channel_mask     <= 4'd0;
            r_cfg.allow_alpha      <= 1'b0;
            r_cfg.luma_threshold   <= 8'd128;
            r_cfg.mirror_threshold <= 1'b0;
            r_cfg.weight_red       <= 8'd77;
            r_cfg.weight_green     <= 8'd150;
            r_cfg.weight_blue      <= 8'd29;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== src/pinv_core.sv =====
// Inversion datapath: luminance test and per-channel inversion for one pixel.
// Depends on pinv_pkg.
`default_nettype none

module pinv_core
    import pinv_pkg::*;
(
    input  wire t_cfg      i_cfg,
    input  wire t_pixel_in i_pixel,
    output t_pixel_out     o_pixel
);

    logic [LUMA_W-1:0] luma_sum;
    logic [CHAN_W-1:0] thresh;
    logic [LUMA_W-1:0] thresh_scaled;
    logic              luma_hit;
    logic              inv_b;
    logic              inv_g;
    logic              inv_r;
    logic              inv_a;

    always_comb begin
        luma_sum = LUMA_W'(i_cfg.weight_red) * LUMA_W'(i_pixel.in_red)
                 + LUMA_W'(i_cfg.weight_green) * LUMA_W'(i_pixel.in_green)
                 + LUMA_W'(i_cfg.weight_blue) * LUMA_W'(i_pixel.in_blue);
        thresh = i_cfg.mirror_threshold ? flip(i_cfg.luma_threshold) : i_cfg.luma_threshold;
        thresh_scaled = {2'b00, thresh, 8'h00};
        luma_hit = luma_sum > thresh_scaled;
    end

    always_comb begin
        inv_b = 1'b0;
        inv_g = 1'b0;
        inv_r = 1'b0;
        inv_a = 1'b0;
        case (i_cfg.mode)
            MODE_SIMPLE: begin
                inv_b = 1'b1;
                inv_g = 1'b1;
                inv_r = 1'b1;
                inv_a = i_cfg.channel_mask[3];
            end
            MODE_CHANNEL: begin
                inv_b = i_cfg.channel_mask[0];
                inv_g = i_cfg.channel_mask[1];
                inv_r = i_cfg.channel_mask[2];
                inv_a = i_cfg.channel_mask[3] & i_cfg.allow_alpha;
            end
            MODE_LUMA: begin
                inv_b = luma_hit;
                inv_g = luma_hit;
                inv_r = luma_hit;
                inv_a = luma_hit & i_cfg.channel_mask[3];
            end
            default: begin
                inv_b = 1'b0;
                inv_g = 1'b0;
                inv_r = 1'b0;
                inv_a = 1'b0;
            end
        endcase
    end

    always_comb begin
        o_pixel.out_blue  = inv_b ? flip(i_pixel.in_blue)  : i_pixel.in_blue;
        o_pixel.out_green = inv_g ? flip(i_pixel.in_green) : i_pixel.in_green;
        o_pixel.out_red   = inv_r ? flip(i_pixel.in_red)   : i_pixel.in_red;
        o_pixel.out_alpha = inv_a ? flip(i_pixel.in_alpha) : i_pixel.in_alpha;
        o_pixel.bad_mode  = (i_cfg.mode == MODE_INVALID);
    end

endmodule

`default_nettype wire
